>>> hw/rtl/hcb_pkg.sv
// Shared constants, codes and control types for the Huffman code builder.
package hcb_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int COUNT_WIDTH  = 32;
    localparam int CODE_WIDTH   = 32;

    localparam int INNER_COUNT = SYMBOL_COUNT - 1;
    localparam int NODE_COUNT  = 2 * SYMBOL_COUNT - 1;
    localparam int SYM_W       = $clog2(SYMBOL_COUNT);
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int INNER_W     = (INNER_COUNT > 1) ? $clog2(INNER_COUNT) : 1;
    localparam int MU_W        = $clog2(INNER_COUNT + 1);
    localparam int WEIGHT_W    = COUNT_WIDTH + SYM_W;
    localparam int LEN_W       = 8;
    localparam int OP_W        = 2;
    localparam int SYMBOL_W    = 8;
    localparam int USED_W      = 9;
    localparam int OUT_CODE_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_COUNT  = 2'd0,
        OP_BUILD  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic KIND_BUILD  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_LOOKUP,
        S_BCLR,
        S_SCAN_A,
        S_END_A,
        S_PICK_A,
        S_SCAN_B,
        S_END_B,
        S_PICK_B,
        S_ROOT,
        S_WALK_RD,
        S_WALK_L,
        S_WALK_R,
        S_BUILD_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic clear_leaf;
        logic idx_clr;
        logic idx_inc;
        logic mu_clr;
        logic scan_init;
        logic scan_step;
        logic count_wr;
        logic take_a;
        logic take_b;
        logic root_init;
        logic walk_rd;
        logic walk_wr_l;
        logic walk_wr_r;
        logic k_dec;
        logic out_build;
        logic out_lookup;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic scan_last;
        logic best_vld;
        logic mu_full;
        logic mu_zero;
        logic k_zero;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/huffman_code_builder.sv
// Top level of the Huffman code builder: controller and datapath.
// Count item: read, then saturating write of the count memory; lookup: read of the code tables, then result.
// Build: one clearing sweep over all 511 nodes, then per merge two scans over the 256 leaves and
// the merged nodes, then a code walk (read, left write, right write) over each merged node.
// One item in work at a time; a finished result waits in the output register.
// Reset (synchronous, active low) runs a clearing sweep over all 511 nodes; input stalls meanwhile.
module huffman_code_builder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hcb_pkg::OP_W-1:0]            i_op,
    input  logic [hcb_pkg::SYMBOL_W-1:0]        i_symbol,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_kind,
    output logic [hcb_pkg::USED_W-1:0]          o_symbols_used,
    output logic [hcb_pkg::OUT_CODE_W-1:0]      o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]           o_code_length
);

    hcb_pkg::t_cmd  cmd;
    hcb_pkg::t_stat stat;

    hcb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    hcb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_symbol       (i_symbol),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_symbols_used (o_symbols_used),
        .o_code_bits    (o_code_bits),
        .o_code_length  (o_code_length)
    );

endmodule

>>> hw/rtl/hcb_ctrl.sv
// Controller state machine for the Huffman code builder.
module hcb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [hcb_pkg::OP_W-1:0]     i_op,
    output logic                         o_stall,
    output hcb_pkg::t_cmd                o_cmd,
    input  hcb_pkg::t_stat               i_stat
);

    hcb_pkg::t_state r_state;
    hcb_pkg::t_state n_state;
    logic            accept;

    assign o_stall = (r_state != hcb_pkg::S_IDLE);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcb_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hcb_pkg::S_CLEAR: begin
                if (i_stat.sweep_last) n_state = hcb_pkg::S_IDLE;
            end
            hcb_pkg::S_IDLE: begin
                if (accept) begin
                    case (hcb_pkg::t_op'(i_op))
                        hcb_pkg::OP_COUNT:  n_state = hcb_pkg::S_COUNT;
                        hcb_pkg::OP_BUILD:  n_state = hcb_pkg::S_BCLR;
                        hcb_pkg::OP_LOOKUP: n_state = hcb_pkg::S_LOOKUP;
                        default:            n_state = hcb_pkg::S_CLEAR;
                    endcase
                end
            end
            hcb_pkg::S_COUNT:  n_state = hcb_pkg::S_IDLE;
            hcb_pkg::S_LOOKUP: begin
                if (i_stat.out_free) n_state = hcb_pkg::S_IDLE;
            end
            hcb_pkg::S_BCLR: begin
                if (i_stat.sweep_last) n_state = hcb_pkg::S_SCAN_A;
            end
            hcb_pkg::S_SCAN_A: begin
                if (i_stat.scan_last) n_state = hcb_pkg::S_END_A;
            end
            hcb_pkg::S_END_A:  n_state = hcb_pkg::S_PICK_A;
            hcb_pkg::S_PICK_A: n_state = i_stat.best_vld ? hcb_pkg::S_SCAN_B : hcb_pkg::S_ROOT;
            hcb_pkg::S_SCAN_B: begin
                if (i_stat.scan_last) n_state = hcb_pkg::S_END_B;
            end
            hcb_pkg::S_END_B:  n_state = hcb_pkg::S_PICK_B;
            hcb_pkg::S_PICK_B: begin
                if (i_stat.best_vld && !i_stat.mu_full) n_state = hcb_pkg::S_SCAN_A;
                else                                     n_state = hcb_pkg::S_ROOT;
            end
            hcb_pkg::S_ROOT: begin
                n_state = i_stat.mu_zero ? hcb_pkg::S_BUILD_OUT : hcb_pkg::S_WALK_RD;
            end
            hcb_pkg::S_WALK_RD: n_state = hcb_pkg::S_WALK_L;
            hcb_pkg::S_WALK_L:  n_state = hcb_pkg::S_WALK_R;
            hcb_pkg::S_WALK_R: begin
                n_state = i_stat.k_zero ? hcb_pkg::S_BUILD_OUT : hcb_pkg::S_WALK_RD;
            end
            hcb_pkg::S_BUILD_OUT: begin
                if (i_stat.out_free) n_state = hcb_pkg::S_IDLE;
            end
            default: n_state = hcb_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            hcb_pkg::S_CLEAR: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.clear_leaf = 1'b1;
                o_cmd.idx_inc    = 1'b1;
                o_cmd.mu_clr     = 1'b1;
            end
            hcb_pkg::S_IDLE: begin
                o_cmd.capture = accept;
                o_cmd.idx_clr = accept;
                o_cmd.mu_clr  = accept;
            end
            hcb_pkg::S_COUNT:  o_cmd.count_wr = 1'b1;
            hcb_pkg::S_LOOKUP: o_cmd.out_lookup = i_stat.out_free;
            hcb_pkg::S_BCLR: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.idx_inc   = 1'b1;
                o_cmd.scan_init = i_stat.sweep_last;
            end
            hcb_pkg::S_SCAN_A, hcb_pkg::S_SCAN_B: o_cmd.scan_step = 1'b1;
            hcb_pkg::S_PICK_A: begin
                o_cmd.take_a    = i_stat.best_vld;
                o_cmd.scan_init = i_stat.best_vld;
            end
            hcb_pkg::S_PICK_B: begin
                o_cmd.take_b    = i_stat.best_vld;
                o_cmd.scan_init = i_stat.best_vld && !i_stat.mu_full;
            end
            hcb_pkg::S_ROOT:    o_cmd.root_init = !i_stat.mu_zero;
            hcb_pkg::S_WALK_RD: o_cmd.walk_rd = 1'b1;
            hcb_pkg::S_WALK_L:  o_cmd.walk_wr_l = 1'b1;
            hcb_pkg::S_WALK_R: begin
                o_cmd.walk_wr_r = 1'b1;
                o_cmd.k_dec     = !i_stat.k_zero;
            end
            hcb_pkg::S_BUILD_OUT: o_cmd.out_build = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/hcb_dp.sv
// Datapath of the Huffman code builder: stores, scan, merge, code walk, output register.
module hcb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hcb_pkg::t_cmd                       i_cmd,
    output hcb_pkg::t_stat                      o_stat,
    input  logic [hcb_pkg::SYMBOL_W-1:0]        i_symbol,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_kind,
    output logic [hcb_pkg::USED_W-1:0]          o_symbols_used,
    output logic [hcb_pkg::OUT_CODE_W-1:0]      o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]           o_code_length
);

    localparam int SYM  = hcb_pkg::SYMBOL_COUNT;
    localparam int NW   = hcb_pkg::NODE_W;
    localparam int IW   = hcb_pkg::INNER_W;
    localparam int SW   = hcb_pkg::SYM_W;
    localparam int CW   = hcb_pkg::CODE_WIDTH;
    localparam int WW   = hcb_pkg::WEIGHT_W;
    localparam int LW   = hcb_pkg::LEN_W;
    localparam int KW   = hcb_pkg::COUNT_WIDTH;

    logic [KW-1:0]     leaf_mem  [hcb_pkg::SYMBOL_COUNT];
    logic [WW-1:0]     mw_mem    [hcb_pkg::INNER_COUNT];
    logic              taken_mem [hcb_pkg::NODE_COUNT];
    logic [2*NW-1:0]   child_mem [hcb_pkg::INNER_COUNT];
    logic [CW+LW-1:0]  inner_mem [hcb_pkg::INNER_COUNT];
    logic [CW-1:0]     code_mem  [hcb_pkg::SYMBOL_COUNT];
    logic [LW-1:0]     len_mem   [hcb_pkg::SYMBOL_COUNT];

    logic [NW-1:0]         r_idx;
    logic [hcb_pkg::MU_W-1:0] r_mu;
    logic [IW-1:0]         r_k;
    logic [hcb_pkg::SYMBOL_W-1:0] r_sym;
    logic                  r_sym_ok;
    logic [hcb_pkg::USED_W-1:0] r_used;
    logic                  r_ev_vld;
    logic [NW-1:0]         r_ev_idx;
    logic                  r_best_vld;
    logic [NW-1:0]         r_best_idx;
    logic [WW-1:0]         r_best_w;
    logic [NW-1:0]         r_a_idx;
    logic [WW-1:0]         r_a_w;

    logic [KW-1:0]         r_leaf_rd;
    logic [WW-1:0]         r_mw_rd;
    logic                  r_taken_rd;
    logic [2*NW-1:0]       r_child_rd;
    logic [CW+LW-1:0]      r_inner_rd;
    logic [CW-1:0]         r_code_rd;
    logic [LW-1:0]         r_len_rd;

    logic                  r_out_vld;
    logic                  r_kind;
    logic [hcb_pkg::USED_W-1:0] r_used_out;
    logic [CW-1:0]         r_code_out;
    logic [LW-1:0]         r_len_out;

    logic [SW-1:0]         leaf_raddr;
    logic [NW-1:0]         mw_off;
    logic [NW-1:0]         scan_lim;
    logic                  sweep_leaf;
    logic [WW-1:0]         ev_w;
    logic                  ev_take;
    logic                  in_sym_ok;
    logic                  walk_side;
    logic                  walk_we;
    logic [NW-1:0]         walk_c;
    logic                  walk_leaf;
    logic [NW-1:0]         walk_inner;
    logic [CW-1:0]         walk_code;
    logic [LW-1:0]         walk_len;
    logic                  out_free;
    logic [IW-1:0]         mu_idx;

    assign in_sym_ok  = ({1'b0, i_symbol} < (hcb_pkg::SYMBOL_W + 1)'(SYM));
    assign leaf_raddr = i_cmd.capture ? i_symbol[SW-1:0] : r_idx[SW-1:0];
    assign mw_off     = r_idx - NW'(SYM);
    assign scan_lim   = NW'(SYM) + NW'(r_mu) - NW'(1);
    assign sweep_leaf = (r_idx < NW'(SYM));
    assign mu_idx     = r_mu[IW-1:0];
    assign out_free   = !r_out_vld || !i_stall;

    assign ev_w    = (r_ev_idx < NW'(SYM)) ? WW'(r_leaf_rd) : r_mw_rd;
    assign ev_take = r_ev_vld && !r_taken_rd && (ev_w != '0)
                     && (!r_best_vld || (ev_w < r_best_w));

    assign walk_side  = i_cmd.walk_wr_r;
    assign walk_we    = i_cmd.walk_wr_l || i_cmd.walk_wr_r;
    assign walk_c     = walk_side ? r_child_rd[NW-1:0] : r_child_rd[2*NW-1:NW];
    assign walk_leaf  = (walk_c < NW'(SYM));
    assign walk_inner = walk_c - NW'(SYM);
    assign walk_code  = {r_inner_rd[CW+LW-2:LW], walk_side};
    assign walk_len   = r_inner_rd[LW-1:0] + LW'(1);

    always_ff @(posedge i_clk) begin
        r_leaf_rd  <= leaf_mem[leaf_raddr];
        r_mw_rd    <= mw_mem[mw_off[IW-1:0]];
        r_taken_rd <= taken_mem[r_idx];
        if ((i_cmd.sweep && sweep_leaf && i_cmd.clear_leaf) || i_cmd.count_wr) begin
            if (i_cmd.count_wr) begin
                if (r_sym_ok) begin
                    leaf_mem[r_sym[SW-1:0]] <= (r_leaf_rd == '1) ? r_leaf_rd
                                                                  : r_leaf_rd + KW'(1);
                end
            end else begin
                leaf_mem[r_idx[SW-1:0]] <= '0;
            end
        end
        if (i_cmd.take_b) begin
            mw_mem[mu_idx]    <= r_a_w + r_best_w;
            child_mem[mu_idx] <= {r_a_idx, r_best_idx};
        end
        if (i_cmd.sweep) begin
            taken_mem[r_idx] <= 1'b0;
        end else if (i_cmd.take_a || i_cmd.take_b) begin
            taken_mem[r_best_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_rd) begin
            r_child_rd <= child_mem[r_k];
            r_inner_rd <= inner_mem[r_k];
        end
        if (i_cmd.root_init) begin
            inner_mem[IW'(r_mu - hcb_pkg::MU_W'(1))] <= '0;
        end else if (walk_we && !walk_leaf) begin
            inner_mem[walk_inner[IW-1:0]] <= {walk_code, walk_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code_rd <= code_mem[i_symbol[SW-1:0]];
            r_len_rd  <= len_mem[i_symbol[SW-1:0]];
        end
        if (i_cmd.sweep && sweep_leaf) begin
            code_mem[r_idx[SW-1:0]] <= '0;
            len_mem[r_idx[SW-1:0]]  <= '0;
        end else if (walk_we && walk_leaf) begin
            code_mem[walk_c[SW-1:0]] <= walk_code;
            len_mem[walk_c[SW-1:0]]  <= walk_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_mu       <= '0;
            r_k        <= '0;
            r_used     <= '0;
            r_ev_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.idx_clr || i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc || i_cmd.scan_step) begin
                r_idx <= r_idx + NW'(1);
            end
            if (i_cmd.mu_clr) begin
                r_mu <= '0;
            end else if (i_cmd.take_b) begin
                r_mu <= r_mu + hcb_pkg::MU_W'(1);
            end
            if (i_cmd.root_init) begin
                r_k <= IW'(r_mu - hcb_pkg::MU_W'(1));
            end else if (i_cmd.k_dec) begin
                r_k <= r_k - IW'(1);
            end
            if (i_cmd.sweep && i_cmd.clear_leaf) begin
                r_used <= '0;
            end else if (i_cmd.count_wr && r_sym_ok && (r_leaf_rd == '0)) begin
                r_used <= r_used + hcb_pkg::USED_W'(1);
            end
            r_ev_vld <= i_cmd.scan_step;
            if (i_cmd.scan_init) begin
                r_best_vld <= 1'b0;
            end else if (ev_take) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.out_build || i_cmd.out_lookup) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx <= r_idx;
        if (i_cmd.capture) begin
            r_sym    <= i_symbol;
            r_sym_ok <= in_sym_ok;
        end
        if (ev_take) begin
            r_best_idx <= r_ev_idx;
            r_best_w   <= ev_w;
        end
        if (i_cmd.take_a) begin
            r_a_idx <= r_best_idx;
            r_a_w   <= r_best_w;
        end
        if (i_cmd.out_build) begin
            r_kind     <= hcb_pkg::KIND_BUILD;
            r_used_out <= r_used;
            r_code_out <= '0;
            r_len_out  <= '0;
        end else if (i_cmd.out_lookup) begin
            r_kind     <= hcb_pkg::KIND_LOOKUP;
            r_used_out <= '0;
            r_code_out <= r_sym_ok ? r_code_rd : '0;
            r_len_out  <= r_sym_ok ? r_len_rd : '0;
        end
    end

    assign o_stat.sweep_last = (r_idx == NW'(hcb_pkg::NODE_COUNT - 1));
    assign o_stat.scan_last  = (r_idx == scan_lim);
    assign o_stat.best_vld   = r_best_vld;
    assign o_stat.mu_full    = (r_mu == hcb_pkg::MU_W'(hcb_pkg::INNER_COUNT - 1));
    assign o_stat.mu_zero    = (r_mu == '0);
    assign o_stat.k_zero     = (r_k == '0);
    assign o_stat.out_free   = out_free;

    assign o_valid        = r_out_vld;
    assign o_kind         = r_kind;
    assign o_symbols_used = r_used_out;
    assign o_code_bits    = OUT_CODE_W_CAST(r_code_out);
    assign o_code_length  = r_len_out;

    function automatic logic [hcb_pkg::OUT_CODE_W-1:0] OUT_CODE_W_CAST(input logic [CW-1:0] c);
        OUT_CODE_W_CAST = hcb_pkg::OUT_CODE_W'(c);
    endfunction

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_build || i_cmd.out_lookup) |-> out_free)
        else $error("result loaded over an untaken result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= hcb_pkg::USED_W'(SYM))
        else $error("symbol count exceeds alphabet");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mu <= hcb_pkg::MU_W'(hcb_pkg::INNER_COUNT))
        else $error("merged node count exceeds tree size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_b |-> (r_best_idx != r_a_idx))
        else $error("node merged with itself");

endmodule
